// File: rtl/core/mmgn_pkg.sv
// Package for the min-max gray normalizer.
// Holds the beat payload types, opcodes and the full-scale constant.
// No dependencies.
`default_nettype none

package mmgn_pkg;

   localparam logic [1:0] OP_FIRST   = 2'd0;
   localparam logic [1:0] OP_MEASURE = 2'd1;
   localparam logic [1:0] OP_SCALE   = 2'd2;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       flat;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/min_max_gray_normalizer.sv
// Top level of the min-max gray normalizer.
// Depends on mmgn_pkg for the beat types, opcodes and full-scale constant.
`default_nettype none

// Measure beats (opcode 0 and 1) update the running extremes in the cycle
// they are accepted and the block is ready again on the next cycle. A scale
// beat (opcode 2) whose sample lies strictly between the extremes passes
// through these steps in order: the offsets, the numerator times 255, eight
// restoring subtract-and-compare steps (one quotient bit each) and the load
// of the result register. Flat range and clamped samples skip the division.
// The result register holds a finished beat while the block takes new
// measure beats; a scale beat waits in its last cycle only if the previous
// result is still stalled. Opcode 3 is accepted and dropped.
module min_max_gray_normalizer #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire mmgn_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output mmgn_pkg::rsp_type     rsp_data
);

   localparam int W = SAMPLE_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_SCALE  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [1:0] MODE_DIV  = 2'd0;
   localparam logic [1:0] MODE_ZERO = 2'd1;
   localparam logic [1:0] MODE_FULL = 2'd2;
   localparam logic [1:0] MODE_FLAT = 2'd3;

   logic [2:0]          state_ff, state_in;
   logic signed [W-1:0] lo_ff, lo_in;
   logic signed [W-1:0] hi_ff, hi_in;
   logic signed [W-1:0] x_ff, x_in;
   logic signed [W-1:0] x_req;
   logic [W-1:0]        num_ff, num_in;
   logic [W-1:0]        den_ff, den_in;
   logic [W:0]          rem_ff, rem_in;
   logic [7:0]          quo_ff, quo_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [1:0]          mode_ff, mode_in;
   logic                out_valid_ff, out_valid_in;
   mmgn_pkg::rsp_type   out_ff, out_in;

   logic [W:0]          num_wide;
   logic [W:0]          den_wide;
   logic [W+7:0]        dividend;
   logic [W:0]          trial;
   logic [W+1:0]        diff;
   logic                borrow;
   logic                accept;
   logic                load_out;
   logic [7:0]          gray;

   generate
      if (W <= 32) begin : g_narrow
         assign x_req = req_data.sample[W-1:0];
      end else begin : g_wide
         assign x_req = {{(W-32){req_data.sample[31]}}, req_data.sample};
      end
   endgenerate

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign num_wide = {x_ff[W-1], x_ff} - {lo_ff[W-1], lo_ff};
   assign den_wide = {hi_ff[W-1], hi_ff} - {lo_ff[W-1], lo_ff};
   assign dividend = {num_ff, 8'd0} - {8'd0, num_ff};
   assign trial    = {rem_ff[W-1:0], quo_ff[7]};
   assign diff     = {1'b0, trial} - {2'b00, den_ff};
   assign borrow   = diff[W+1];
   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      case (mode_ff)
         MODE_DIV:  gray = quo_ff;
         MODE_FULL: gray = mmgn_pkg::FULL_SCALE;
         default:   gray = 8'd0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      x_in         = x_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in = x_req;
               unique case (req_data.opcode)
                  mmgn_pkg::OP_FIRST: begin
                     lo_in = x_req;
                     hi_in = x_req;
                  end
                  mmgn_pkg::OP_MEASURE: begin
                     if (x_req < lo_ff) begin
                        lo_in = x_req;
                     end
                     if (x_req > hi_ff) begin
                        hi_in = x_req;
                     end
                  end
                  mmgn_pkg::OP_SCALE: begin
                     state_in = ST_SETUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SETUP: begin
            num_in = num_wide[W-1:0];
            den_in = den_wide[W-1:0];
            if (hi_ff <= lo_ff) begin
               mode_in  = MODE_FLAT;
               state_in = ST_DONE;
            end else if (x_ff <= lo_ff) begin
               mode_in  = MODE_ZERO;
               state_in = ST_DONE;
            end else if (x_ff >= hi_ff) begin
               mode_in  = MODE_FULL;
               state_in = ST_DONE;
            end else begin
               mode_in  = MODE_DIV;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            rem_in   = {1'b0, dividend[W+7:8]};
            quo_in   = dividend[7:0];
            cnt_in   = 3'd0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = borrow ? trial : diff[W:0];
            quo_in = {quo_ff[6:0], ~borrow};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_in.red   = gray;
               out_in.green = gray;
               out_in.blue  = gray;
               out_in.flat  = (mode_ff == MODE_FLAT);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lo_ff        <= '0;
         hi_ff        <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= 3'd0;
         mode_ff      <= MODE_FLAT;
      end else begin
         state_ff     <= state_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for min_max_gray_normalizer: a directed table, then random measure and scale frames.
// Checked against typed rows, else an in-bench gray-stretch predictor; bursty sending and stalling.
// Depends on mmgn_pkg and the min_max_gray_normalizer RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 1500;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int TAIL_CYCLES = 24;
   localparam int LONG_HOLD = 600;
   localparam int STEP_COUNT = 25;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] sample;
      logic        typed;
      logic [7:0]  gray;
      logic        flat;
   } gray_step_type;

   typedef struct packed {
      mmgn_pkg::req_type beat;
      logic              typed;
      mmgn_pkg::rsp_type want;
   } queued_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mmgn_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mmgn_pkg::rsp_type rsp_data;

   queued_beat_type   cur_beat = '0;
   queued_beat_type   beat_script[$];
   mmgn_pkg::rsp_type pending_grays[$];
   mmgn_pkg::rsp_type oldest_gray;
   mmgn_pkg::rsp_type next_gray;
   logic              next_emits;
   logic signed [31:0] span_low = '0;
   logic signed [31:0] span_high = '0;
   int                fault_count = 0;
   int                cycle_count = 0;

   gray_step_type gray_steps [STEP_COUNT] = '{
      '{mmgn_pkg::OP_SCALE,   32'h0000_0000, 1'b1, 8'd0,   1'b1},
      '{mmgn_pkg::OP_MEASURE, 32'hFFFF_FFFB, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_0000, 1'b1, 8'd255, 1'b0},
      '{mmgn_pkg::OP_SCALE,   32'hFFFF_FFFB, 1'b1, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'hFFFF_FFFD, 1'b0, 8'd0,   1'b0},
      '{OP_UNUSED,            32'h0000_007B, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_FIRST,   32'h8000_0000, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h8000_0000, 1'b1, 8'd0,   1'b1},
      '{mmgn_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h8000_0000, 1'b1, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h7FFF_FFFF, 1'b1, 8'd255, 1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_0000, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'hFFFF_FFFF, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_FIRST,   32'h0064_0000, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_MEASURE, 32'h00C8_0000, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0096_0000, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0032_0000, 1'b1, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h00FA_0000, 1'b1, 8'd255, 1'b0},
      '{OP_UNUSED,            32'hFFFF_FFFF, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_FIRST,   32'h0000_002A, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_002A, 1'b1, 8'd0,   1'b1},
      '{mmgn_pkg::OP_MEASURE, 32'h0000_002B, 1'b0, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_002A, 1'b1, 8'd0,   1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_002B, 1'b1, 8'd255, 1'b0},
      '{mmgn_pkg::OP_SCALE,   32'h0000_002C, 1'b1, 8'd255, 1'b0}
   };

   min_max_gray_normalizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void stretch_gray(input mmgn_pkg::req_type beat, output logic emits,
                                        output mmgn_pkg::rsp_type res);
      logic signed [31:0] x;
      longint num;
      longint den;
      longint gray;
      x = beat.sample;
      gray = 0;
      emits = 1'b0;
      res = '0;
      case (beat.opcode)
         mmgn_pkg::OP_FIRST: begin
            span_low = x;
            span_high = x;
         end
         mmgn_pkg::OP_MEASURE: begin
            if (x < span_low) span_low = x;
            if (x > span_high) span_high = x;
         end
         mmgn_pkg::OP_SCALE: begin
            emits = 1'b1;
            if (span_high <= span_low) begin
               res.flat = 1'b1;
            end else if (x <= span_low) begin
               gray = 0;
            end else if (x >= span_high) begin
               gray = longint'(mmgn_pkg::FULL_SCALE);
            end else begin
               num = longint'(x) - longint'(span_low);
               den = longint'(span_high) - longint'(span_low);
               gray = num * longint'(mmgn_pkg::FULL_SCALE) / den;
               if (gray > longint'(mmgn_pkg::FULL_SCALE)) begin
                  gray = longint'(mmgn_pkg::FULL_SCALE);
               end
            end
            res.red = gray[7:0];
            res.green = gray[7:0];
            res.blue = gray[7:0];
         end
         default: ;
      endcase
   endfunction

   task automatic queue_beat(input mmgn_pkg::req_type beat, input logic typed,
                             input mmgn_pkg::rsp_type want);
      queued_beat_type entry;
      entry.beat = beat;
      entry.typed = typed;
      entry.want = want;
      beat_script.push_back(entry);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_grays.size() == 0) begin
               $error("unexpected result beat: red %0d flat %0d", rsp_data.red, rsp_data.flat);
               fault_count++;
            end else begin
               oldest_gray = pending_grays.pop_front();
               if (rsp_data.red !== oldest_gray.red) begin
                  $error("red: expected %0d, got %0d", oldest_gray.red, rsp_data.red);
                  fault_count++;
               end
               if (rsp_data.green !== oldest_gray.green) begin
                  $error("green: expected %0d, got %0d", oldest_gray.green, rsp_data.green);
                  fault_count++;
               end
               if (rsp_data.blue !== oldest_gray.blue) begin
                  $error("blue: expected %0d, got %0d", oldest_gray.blue, rsp_data.blue);
                  fault_count++;
               end
               if (rsp_data.flat !== oldest_gray.flat) begin
                  $error("flat: expected %0d, got %0d", oldest_gray.flat, rsp_data.flat);
                  fault_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            stretch_gray(req_data, next_emits, next_gray);
            if (next_emits) pending_grays.push_back(cur_beat.typed ? cur_beat.want : next_gray);
         end
      end
   end

   initial begin
      int rx_cycles;
      int next_hold;
      int seg_len;
      int mode;
      rx_cycles = 0;
      next_hold = 1500;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_cycles >= next_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rx_cycles += LONG_HOLD;
            next_hold += 6000;
         end
         seg_len = $urandom_range(10, 150);
         mode = $urandom_range(0, 3);
         repeat (seg_len) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= rx_cycles[0];
            endcase
            rx_cycles++;
            @(posedge clock);
         end
      end
   end

   initial begin
      mmgn_pkg::req_type beat;
      gray_step_type row;
      logic [31:0] span;
      logic [31:0] base;
      int counted;
      int burst_left;
      int gap;
      int drain_at;
      for (int i = 0; i < STEP_COUNT; i++) begin
         row = gray_steps[i];
         beat.opcode = row.opcode;
         beat.sample = row.sample;
         queue_beat(beat, row.typed, '{red: row.gray, green: row.gray, blue: row.gray,
                                       flat: row.flat});
      end
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            beat.opcode = 2'($urandom_range(0, 3));
            beat.sample = $urandom;
            queue_beat(beat, 1'b0, '0);
            if (beat.opcode != OP_UNUSED) counted++;
         end else begin
            case ($urandom_range(0, 3))
               0: span = '0;
               1: span = $urandom_range(1, 16);
               2: span = $urandom_range(17, 32'h000F_FFFF);
               default: span = $urandom;
            endcase
            base = $urandom;
            beat.opcode = mmgn_pkg::OP_FIRST;
            beat.sample = base + $urandom_range(0, span);
            queue_beat(beat, 1'b0, '0);
            counted++;
            repeat ($urandom_range(0, 5)) begin
               beat.opcode = mmgn_pkg::OP_MEASURE;
               beat.sample = base + $urandom_range(0, span);
               queue_beat(beat, 1'b0, '0);
               counted++;
            end
            repeat ($urandom_range(1, 10)) begin
               beat.opcode = mmgn_pkg::OP_SCALE;
               case ($urandom_range(0, 9))
                  7: beat.sample = base;
                  8: beat.sample = base + span;
                  9: beat.sample = $urandom;
                  default: beat.sample = base + $urandom_range(0, span);
               endcase
               queue_beat(beat, 1'b0, '0);
               counted++;
            end
         end
      end
      drain_at = beat_script.size() / 2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;
      for (int idx = 0; idx < beat_script.size(); idx++) begin
         if (idx == drain_at) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_grays.size() != 0) @(posedge clock);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap != 0 && idx != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (burst_left > 0) burst_left--;
         req_valid <= 1'b1;
         req_data <= beat_script[idx].beat;
         cur_beat <= beat_script[idx];
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grays.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mmgn_pkg.sv
rtl/core/min_max_gray_normalizer.sv
tb/tb_top.sv
